// ===== rtl/box_filter_3x3_edge_aware_top_macros.svh =====
`ifndef BOX_FILTER_3X3_EDGE_AWARE_TOP_MACROS_SVH
`define BOX_FILTER_3X3_EDGE_AWARE_TOP_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define BF3_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define BF3_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/bf3_pkg.sv =====
package bf3_pkg;

   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;

   localparam int PIX_W     = 8;
   localparam int CFG_W     = 9;
   localparam int CSR_IDX_W = 4;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = CSR_IDX_W'(1);

   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(256);

   // nine 8-bit cells
   localparam int SUM_W = 12;

   // reciprocals for floor division of values below 2^15
   localparam int                 RECIP_SHIFT = 16;
   localparam int                 RECIP_W     = 15;
   localparam logic [RECIP_W-1:0] RECIP_3     = RECIP_W'(21846);
   localparam logic [RECIP_W-1:0] RECIP_9     = RECIP_W'(7282);

   localparam int FIFO_DEPTH = 4;

   typedef enum logic [2:0] {
      DIV_1,
      DIV_2,
      DIV_3,
      DIV_4,
      DIV_6,
      DIV_9
   } bf3_div_type;

   // per-item control decided at accept time
   typedef struct packed {
      logic go;       // item advances the window
      logic emit;     // item releases a result
      logic last;     // that result ends the frame
      logic wr;       // item carries a pixel (not tail)
      logic restart;  // counters and window return to zero
      logic top;
      logic bot;
      logic left;
      logic right;
   } bf3_step_type;

   typedef struct packed {
      logic              valid;
      logic              last;
      bf3_div_type       div;
      logic [SUM_W-1:0]  sum;
   } bf3_acc_type;

   typedef struct packed {
      logic              valid;
      logic              last;
      logic [PIX_W-1:0]  value;
   } bf3_res_type;

endpackage

// ===== rtl/bf3_line_ram.sv =====
module bf3_line_ram import bf3_pkg::*; #(
   parameter int DEPTH = MAX_WIDTH_DEF,
   parameter int DW    = PIX_W
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [DW-1:0]                              wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [DW-1:0]                              rd_data
);

   logic [DW-1:0] line_mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   // read-first: a read and a write at one address return the old word
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= line_mem[rd_addr];
      end
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bf3_ctrl.sv =====
`include "box_filter_3x3_edge_aware_top_macros.svh"

module bf3_ctrl import bf3_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           csr_valid,
   input  logic [CSR_IDX_W-1:0]                           csr_index,
   input  logic [CFG_W-1:0]                               csr_wdata,
   input  logic                                           req_fire,
   input  logic                                           req_flush,
   output bf3_step_type                                   step,
   output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] step_addr,
   output logic                                           frame_clear
);

   localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW  = $clog2(MAX_HEIGHT + 2);
   localparam int CW1 = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
   localparam int CW2 = (RW > CW1) ? RW : CW1;
   localparam int CW  = CW2 + 1;

   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic [AW-1:0]    col_ff, col_in;
   logic [RW-1:0]    row_ff, row_in;

   logic [CW-1:0] w_ext, h_ext, w_eff, h_eff, col_ext, row_ext;
   logic          wr_width, wr_height;
   logic          tail, go, emit_a, emit_b, restart, col_wrap;

   assign wr_width    = csr_valid && (csr_index == REG_IMAGE_WIDTH);
   assign wr_height   = csr_valid && (csr_index == REG_IMAGE_HEIGHT);
   assign frame_clear = wr_width || wr_height;

   assign w_ext   = CW'(width_ff);
   assign h_ext   = CW'(height_ff);
   assign col_ext = CW'(col_ff);
   assign row_ext = CW'(row_ff);

   // zero reads as one, anything above the maximum as the maximum
   always_comb begin
      if (w_ext == '0) begin
         w_eff = CW'(1);
      end else if (w_ext > CW'(MAX_WIDTH)) begin
         w_eff = CW'(MAX_WIDTH);
      end else begin
         w_eff = w_ext;
      end
      if (h_ext == '0) begin
         h_eff = CW'(1);
      end else if (h_ext > CW'(MAX_HEIGHT)) begin
         h_eff = CW'(MAX_HEIGHT);
      end else begin
         h_eff = h_ext;
      end
   end

   assign tail     = row_ext >= h_eff;
   assign go       = req_fire && (tail || !req_flush);
   assign emit_a   = (col_ff == '0) && (row_ext >= CW'(2));
   assign emit_b   = (col_ff != '0) && (row_ext != '0);
   assign restart  = row_ext == (h_eff + CW'(1));
   assign col_wrap = (col_ext + CW'(1)) == w_eff;

   // row-end centre (emit_a) and in-row centre (emit_b) share one window view
   always_comb begin
      step.go      = go;
      step.emit    = go && (emit_a || emit_b);
      step.last    = emit_a && restart;
      step.wr      = !tail;
      step.restart = restart;
      step.top     = emit_a ? (row_ext >= CW'(3)) : (row_ext >= CW'(2));
      step.bot     = emit_a ? (row_ext <= h_eff) : (row_ext < h_eff);
      step.left    = emit_a ? (w_eff >= CW'(2)) : (col_ext >= CW'(2));
      step.right   = !emit_a;
   end

   assign step_addr = col_ff;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (wr_width) begin
         width_in = csr_wdata;
      end
      if (wr_height) begin
         height_in = csr_wdata;
      end
      if (frame_clear) begin
         col_in = '0;
         row_in = '0;
      end else if (go) begin
         if (restart) begin
            col_in = '0;
            row_in = '0;
         end else if (col_wrap) begin
            col_in = '0;
            row_in = row_ff + RW'(1);
         end else begin
            col_in = col_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_RESET;
         height_ff <= CFG_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   `BF3_ASSERT_IMPL(a_row_bound, 1'b1, row_ext <= (h_eff + CW'(1)), "row past tail")
   `BF3_ASSERT_IMPL(a_col_bound, 1'b1, col_ext < w_eff, "column past width")

endmodule

// ===== rtl/bf3_window.sv =====
module bf3_window import bf3_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  bf3_step_type                                   step,
   input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] step_addr,
   input  logic [PIX_W-1:0]                               step_pixel,
   input  logic                                           frame_clear,
   output bf3_acc_type                                    acc,
   output logic [1:0]                                     pend
);

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   bf3_step_type     s1_ff;
   logic [AW-1:0]    s1_addr_ff;
   logic [PIX_W-1:0] s1_pix_ff, s1_pix_in;
   logic             fwd_ff, fwd_in;
   logic [PIX_W-1:0] fwd_data_ff;
   logic [PIX_W-1:0] win_ff [3][3];
   logic [PIX_W-1:0] win_in [3][3];
   logic [PIX_W-1:0] shift_win [3][3];
   logic [PIX_W-1:0] up_rdata, mid_rdata, top_pix;
   logic             up_wr, mid_wr;
   logic             rm [3];
   logic             cm [3];
   logic [SUM_W-1:0] term [3][3];
   logic [SUM_W-1:0] row_sum [3];
   logic [SUM_W-1:0] total;
   logic [1:0]       rn, cn;
   bf3_div_type      div;
   bf3_acc_type      acc_ff, acc_in;

   assign mid_wr = step.go && step.wr;
   assign up_wr  = s1_ff.go && s1_ff.wr;

   // middle row: written with the incoming pixel at accept
   bf3_line_ram #(.DEPTH(MAX_WIDTH), .DW(PIX_W)) u_mid_ram (
      .clock   (clock),
      .wr_en   (mid_wr),
      .wr_addr (step_addr),
      .wr_data (step_pixel),
      .rd_en   (step.go),
      .rd_addr (step_addr),
      .rd_data (mid_rdata)
   );

   // upper row: takes the old middle word in the cycle after the accept
   bf3_line_ram #(.DEPTH(MAX_WIDTH), .DW(PIX_W)) u_up_ram (
      .clock   (clock),
      .wr_en   (up_wr),
      .wr_addr (s1_addr_ff),
      .wr_data (mid_rdata),
      .rd_en   (step.go),
      .rd_addr (step_addr),
      .rd_data (up_rdata)
   );

   // bypass the upper write that lands in the same cycle as a read of it
   assign fwd_in    = step.go && up_wr && (s1_addr_ff == step_addr);
   assign top_pix   = fwd_ff ? fwd_data_ff : up_rdata;
   assign s1_pix_in = step.wr ? step_pixel : '0;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         shift_win[r][0] = win_ff[r][1];
         shift_win[r][1] = win_ff[r][2];
      end
      shift_win[0][2] = top_pix;
      shift_win[1][2] = mid_rdata;
      shift_win[2][2] = s1_pix_ff;
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if (frame_clear || (s1_ff.go && s1_ff.restart)) begin
               win_in[r][c] = '0;
            end else if (s1_ff.go) begin
               win_in[r][c] = shift_win[r][c];
            end else begin
               win_in[r][c] = win_ff[r][c];
            end
         end
      end
   end

   assign rm[0] = s1_ff.top;
   assign rm[1] = 1'b1;
   assign rm[2] = s1_ff.bot;
   assign cm[0] = s1_ff.left;
   assign cm[1] = 1'b1;
   assign cm[2] = s1_ff.right;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            term[r][c] = (rm[r] && cm[c]) ? SUM_W'(shift_win[r][c]) : '0;
         end
      end
      for (int r = 0; r < 3; r++) begin
         row_sum[r] = term[r][0] + term[r][1] + term[r][2];
      end
      total = row_sum[0] + row_sum[1] + row_sum[2];
   end

   assign rn = 2'd1 + 2'(s1_ff.top) + 2'(s1_ff.bot);
   assign cn = 2'd1 + 2'(s1_ff.left) + 2'(s1_ff.right);

   always_comb begin
      case ({rn, cn})
         {2'd1, 2'd1}: div = DIV_1;
         {2'd1, 2'd2}: div = DIV_2;
         {2'd2, 2'd1}: div = DIV_2;
         {2'd1, 2'd3}: div = DIV_3;
         {2'd3, 2'd1}: div = DIV_3;
         {2'd2, 2'd2}: div = DIV_4;
         {2'd2, 2'd3}: div = DIV_6;
         {2'd3, 2'd2}: div = DIV_6;
         {2'd3, 2'd3}: div = DIV_9;
         default:      div = DIV_1;
      endcase
   end

   always_comb begin
      acc_in.valid = s1_ff.emit;
      acc_in.last  = s1_ff.last;
      acc_in.div   = div;
      acc_in.sum   = total;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff        <= '0;
         fwd_ff       <= 1'b0;
         acc_ff.valid <= 1'b0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else begin
         s1_ff        <= step;
         fwd_ff       <= fwd_in;
         acc_ff.valid <= acc_in.valid;
         win_ff       <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff  <= step_addr;
      s1_pix_ff   <= s1_pix_in;
      fwd_data_ff <= mid_rdata;
      acc_ff.last <= acc_in.last;
      acc_ff.div  <= acc_in.div;
      acc_ff.sum  <= acc_in.sum;
   end

   assign acc  = acc_ff;
   assign pend = 2'(s1_ff.emit) + 2'(acc_ff.valid);

endmodule

// ===== rtl/bf3_mean.sv =====
module bf3_mean import bf3_pkg::*; (
   input  bf3_acc_type acc,
   output bf3_res_type res
);

   logic [SUM_W+RECIP_W-1:0] prod3, prod9;
   logic [SUM_W-1:0]         q3, q9, quot;

   assign prod3 = (SUM_W + RECIP_W)'(acc.sum) * (SUM_W + RECIP_W)'(RECIP_3);
   assign prod9 = (SUM_W + RECIP_W)'(acc.sum) * (SUM_W + RECIP_W)'(RECIP_9);
   assign q3    = SUM_W'(prod3 >> RECIP_SHIFT);
   assign q9    = SUM_W'(prod9 >> RECIP_SHIFT);

   always_comb begin
      case (acc.div)
         DIV_1:   quot = acc.sum;
         DIV_2:   quot = acc.sum >> 1;
         DIV_3:   quot = q3;
         DIV_4:   quot = acc.sum >> 2;
         DIV_6:   quot = q3 >> 1;
         DIV_9:   quot = q9;
         default: quot = acc.sum;
      endcase
   end

   assign res.valid = acc.valid;
   assign res.last  = acc.last;
   assign res.value = quot[PIX_W-1:0];

endmodule

// ===== rtl/bf3_out_fifo.sv =====
`include "box_filter_3x3_edge_aware_top_macros.svh"

module bf3_out_fifo import bf3_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  bf3_res_type                   push,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [PIX_W-1:0]              rsp_smoothed_value,
   output logic                          rsp_frame_last,
   output logic [$clog2(FIFO_DEPTH):0]   level
);

   localparam int PW = $clog2(FIFO_DEPTH);
   localparam int CW = PW + 1;

   logic [PIX_W-1:0] val_ff  [FIFO_DEPTH];
   logic             last_ff [FIFO_DEPTH];
   logic [PW-1:0]    wptr_ff, wptr_in;
   logic [PW-1:0]    rptr_ff, rptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push_en, pop, grow;

   assign push_en = push.valid;
   assign pop     = rsp_valid && rsp_ready;
   assign grow    = push_en && !pop;

   always_comb begin
      wptr_in  = push_en ? wptr_ff + PW'(1) : wptr_ff;
      rptr_in  = pop ? rptr_ff + PW'(1) : rptr_ff;
      case ({push_en, pop})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         val_ff[wptr_ff]  <= push.value;
         last_ff[wptr_ff] <= push.last;
      end
   end

   assign rsp_valid          = count_ff != '0;
   assign rsp_smoothed_value = val_ff[rptr_ff];
   assign rsp_frame_last     = last_ff[rptr_ff];
   assign level              = count_ff;

   `BF3_ASSERT_IMPL(a_fifo_no_overflow, grow, count_ff != CW'(FIFO_DEPTH), "result fifo overflow")
   `BF3_ASSERT_NEXT(a_fifo_level_up, grow, count_ff == $past(count_ff) + CW'(1), "fifo lost a push")

endmodule

// ===== rtl/box_filter_3x3_edge_aware_top.sv =====
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_ready  | req_pixel_value, req_flush
// rsp     | out       | rsp_valid/rsp_ready  | rsp_smoothed_value, rsp_frame_last
// csr     | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//
// One item per clock sustained while req_ready is high; the line RAMs take one read and
// one write each per cycle. rsp_valid rises once a result released by a transfer has
// passed the line RAM read at the transfer edge, the window sum register and result fifo.
// Reset clears counters, window, pipeline and fifo; line RAMs keep their contents.
// req_ready drops while the fifo plus results in flight reach the fifo depth of four.
module box_filter_3x3_edge_aware_top import bf3_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [PIX_W-1:0]      req_pixel_value,
   input  logic                  req_flush,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PIX_W-1:0]      rsp_smoothed_value,
   output logic                  rsp_frame_last,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_wdata
);

   localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CNT_W = $clog2(FIFO_DEPTH) + 2;

   bf3_step_type              step;
   logic [AW-1:0]             step_addr;
   logic                      frame_clear;
   logic                      req_fire;
   bf3_acc_type               acc;
   bf3_res_type               res;
   logic [1:0]                pend;
   logic [$clog2(FIFO_DEPTH):0] fifo_level;
   logic [CNT_W-1:0]          inflight;

   // Configuration must be written only while idle; unchecked, each csr is taken at once.
   assign csr_ready = 1'b1;

   // Credit: hold req while every fifo slot is claimed by a stored or in-flight result.
   assign inflight  = CNT_W'(fifo_level) + CNT_W'(pend);
   assign req_ready = inflight < CNT_W'(FIFO_DEPTH);
   assign req_fire  = req_valid && req_ready;

   // Raster counters and per-item decisions: emit, border masks, frame end.
   bf3_ctrl #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_fire    (req_fire),
      .req_flush   (req_flush),
      .step        (step),
      .step_addr   (step_addr),
      .frame_clear (frame_clear)
   );

   // Line RAM read-modify-write, 3x3 window shift and masked sum.
   bf3_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .step_addr   (step_addr),
      .step_pixel  (req_pixel_value),
      .frame_clear (frame_clear),
      .acc         (acc),
      .pend        (pend)
   );

   // Divide by the count of cells present (1, 2, 3, 4, 6 or 9).
   bf3_mean u_mean (
      .acc (acc),
      .res (res)
   );

   // Decouple results from rsp stalls; the pipeline itself never stalls.
   bf3_out_fifo u_fifo (
      .clock              (clock),
      .reset              (reset),
      .push               (res),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_smoothed_value (rsp_smoothed_value),
      .rsp_frame_last     (rsp_frame_last),
      .level              (fifo_level)
   );

endmodule

// ===== tb/tb_box_filter_3x3_edge_aware_top.sv =====
module tb_box_filter_3x3_edge_aware_top;
   import bf3_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_HALF    = 5;
   localparam int RESET_LEN   = 8;
   localparam int SETTLE      = 12;        // quiet cycles before a register write or the end
   localparam int HOLD_CYCLES = 300;       // long receiver hold-off
   localparam int RUN_LIMIT   = 1000000;
   localparam int RANDOM_ITEMS = 1800;

   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED = CSR_IDX_W'(15);

   typedef enum {OP_ITEM, OP_CSR, OP_DRAIN, OP_PACE, OP_HOLD} stim_op_type;

   typedef struct {
      stim_op_type           op;
      logic [PIX_W-1:0]      pixel;
      logic                  flush;
      logic [CSR_IDX_W-1:0]  csr_idx;
      logic [CFG_W-1:0]      csr_data;
      int                    send_idle;
      int                    recv_stall;
   } stim_type;

   typedef struct packed {
      logic [PIX_W-1:0] value;
      logic             last;
   } smooth_res_type;

   // ------------------------------------------------------------------
   // Clock, reset and DUT hookup. Every input starts at a known value.
   // ------------------------------------------------------------------
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [PIX_W-1:0]      req_pixel_value = '0;
   logic                  req_flush = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [PIX_W-1:0]      rsp_smoothed_value;
   logic                  rsp_frame_last;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CFG_W-1:0]      csr_wdata = '0;

   always #CLK_HALF clock = ~clock;

   box_filter_3x3_edge_aware_top DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_pixel_value    (req_pixel_value),
      .req_flush          (req_flush),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_smoothed_value (rsp_smoothed_value),
      .rsp_frame_last     (rsp_frame_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // ------------------------------------------------------------------
   // Shared bookkeeping between the driver, the monitor and the run control.
   // ------------------------------------------------------------------
   stim_type        stim_queue[$];       // pending transfers and pacing markers
   smooth_res_type  smoothed_expect[$];  // predicted results, oldest first
   int           mismatch_count = 0;
   int           cycle_count = 0;
   logic         stim_done = 1'b0;
   int           rsp_stall_pct = 0;   // receiver stall rate, set by the driver
   logic         hold_toggle = 1'b0;  // flip to start a long receiver hold-off

   // ------------------------------------------------------------------
   // Filter predictor: line buffers, 3x3 window, raster position, geometry.
   // ------------------------------------------------------------------
   logic [PIX_W-1:0] line_upper  [MAX_WIDTH_DEF];
   logic [PIX_W-1:0] line_middle [MAX_WIDTH_DEF];
   logic [PIX_W-1:0] win [3][3];      // [upper, middle, lower][oldest .. newest]
   int unsigned      cur_col, cur_row, results_in_frame;
   logic [CFG_W-1:0] width_reg, height_reg;

   function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   // Floor mean around window column cc over the rows and columns present.
   function automatic logic [PIX_W-1:0] neighborhood_mean(int unsigned cc, bit top, bit bot,
                                                          bit left, bit right);
      int unsigned sum, cnt;
      sum = 0;
      cnt = 0;
      for (int r = 0; r < 3; r++) begin
         if ((r == 0 && !top) || (r == 2 && !bot)) continue;
         for (int d = 0; d < 3; d++) begin
            if ((d == 0 && !left) || (d == 2 && !right)) continue;
            sum += win[r][cc + d - 1];
            cnt++;
         end
      end
      return (cnt != 0) ? PIX_W'(sum / cnt) : '0;
   endfunction

   task automatic restart_frame();
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            win[r][c] = '0;
      cur_col = 0;
      cur_row = 0;
      results_in_frame = 0;
   endtask

   task automatic write_geometry(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == REG_IMAGE_WIDTH) width_reg = data;
      else if (idx == REG_IMAGE_HEIGHT) height_reg = data;
      else return;
      restart_frame();
   endtask

   task automatic predict_item(logic [PIX_W-1:0] pix, logic flush);
      int unsigned      w, h, i, j;
      bit               tail, emit, last;
      logic [PIX_W-1:0] val, top_px, mid_px, bot_px;
      w = clamp_dim(width_reg, MAX_WIDTH_DEF);
      h = clamp_dim(height_reg, MAX_HEIGHT_DEF);
      i = cur_row;
      j = cur_col;
      tail = (i >= h);
      emit = 1'b0;
      last = 1'b0;
      val = '0;
      if (!tail && flush) return;      // no advance before the last pixel
      if (j >= w) j = 0;
      // centre at the end of the previous row, before the window shifts
      if (j == 0 && i >= 2) begin
         val = neighborhood_mean(2, i >= 3, i <= h, w >= 2, 1'b0);
         emit = 1'b1;
      end
      top_px = line_upper[j];
      mid_px = line_middle[j];
      bot_px = '0;
      if (!tail) begin
         bot_px = pix;
         line_upper[j] = mid_px;
         line_middle[j] = bot_px;
      end
      for (int r = 0; r < 3; r++) begin
         win[r][0] = win[r][1];
         win[r][1] = win[r][2];
      end
      win[0][2] = top_px;
      win[1][2] = mid_px;
      win[2][2] = bot_px;
      if (j >= 1 && i >= 1) begin
         val = neighborhood_mean(1, i >= 2, i < h, j >= 2, 1'b1);
         emit = 1'b1;
      end
      if (emit) begin
         last = (results_in_frame + 1 >= w * h);
         results_in_frame++;
      end
      if (last || i > h) restart_frame();
      else begin
         j++;
         if (j >= w) begin
            j = 0;
            i++;
         end
         cur_col = j;
         cur_row = i;
      end
      if (emit) smoothed_expect.push_back('{value: val, last: last});
   endtask

   // ------------------------------------------------------------------
   // Driver: predict each accepted transfer, then pick the next one from the
   // queue. Hold valid and payload until accepted. Register writes and drain
   // markers wait until nothing is offered and no result is owed.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : driver
      stim_type s;
      logic  nxt_req_valid, nxt_csr_valid, nxt_hold, stop;
      int    nxt_stall;
      static int sender_pct = 0;
      static int quiet = 0;
      if (reset) begin
         req_valid <= 1'b0;
         req_pixel_value <= '0;
         req_flush <= 1'b0;
         csr_valid <= 1'b0;
         csr_index <= '0;
         csr_wdata <= '0;
         width_reg = CFG_RESET;
         height_reg = CFG_RESET;
         for (int k = 0; k < MAX_WIDTH_DEF; k++) begin
            line_upper[k] = '0;
            line_middle[k] = '0;
         end
         restart_frame();
         quiet = 0;
      end else begin
         if (req_valid && req_ready) predict_item(req_pixel_value, req_flush);
         if (csr_valid && csr_ready) write_geometry(csr_index, csr_wdata);

         nxt_req_valid = req_valid && !req_ready;
         nxt_csr_valid = csr_valid && !csr_ready;
         nxt_hold = hold_toggle;
         nxt_stall = rsp_stall_pct;

         // count cycles with nothing offered and nothing owed
         if (!nxt_req_valid && !nxt_csr_valid && smoothed_expect.size() == 0) quiet++;
         else quiet = 0;

         stop = nxt_req_valid || nxt_csr_valid;
         while (!stop && stim_queue.size() != 0) begin
            s = stim_queue[0];
            case (s.op)
               OP_PACE: begin
                  sender_pct = s.send_idle;
                  nxt_stall = s.recv_stall;
                  void'(stim_queue.pop_front());
               end
               OP_HOLD: begin
                  nxt_hold = ~nxt_hold;
                  void'(stim_queue.pop_front());
               end
               OP_DRAIN: begin
                  if (quiet >= SETTLE) void'(stim_queue.pop_front());
                  else stop = 1'b1;
               end
               OP_CSR: begin
                  if (quiet >= SETTLE) begin
                     nxt_csr_valid = 1'b1;
                     csr_index <= s.csr_idx;
                     csr_wdata <= s.csr_data;
                     void'(stim_queue.pop_front());
                  end
                  stop = 1'b1;
               end
               default: begin
                  if ($urandom_range(99, 0) >= sender_pct) begin
                     nxt_req_valid = 1'b1;
                     req_pixel_value <= s.pixel;
                     req_flush <= s.flush;
                     void'(stim_queue.pop_front());
                  end
                  stop = 1'b1;
               end
            endcase
         end

         req_valid <= nxt_req_valid;
         csr_valid <= nxt_csr_valid;
         hold_toggle <= nxt_hold;
         rsp_stall_pct <= nxt_stall;
         if (stim_queue.size() == 0 && !nxt_req_valid && !nxt_csr_valid && quiet >= SETTLE)
            stim_done <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Monitor: compare each result transfer with the oldest prediction and
   // drive rsp_ready, including the long hold-off counted here.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      smooth_res_type want;
      static logic hold_seen = 1'b0;
      static int   hold_left = 0;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_seen = hold_toggle;
         hold_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (smoothed_expect.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected result: value %0d last %0b",
                           rsp_smoothed_value, rsp_frame_last);
               mismatch_count++;
            end else begin
               want = smoothed_expect.pop_front();
               if (want.value !== rsp_smoothed_value || want.last !== rsp_frame_last) begin
                  if (mismatch_count < 10)
                     $display("mismatch: expected value %0d last %0b, got value %0d last %0b",
                              want.value, want.last, rsp_smoothed_value, rsp_frame_last);
                  mismatch_count++;
               end
            end
         end
         if (hold_toggle != hold_seen) begin
            hold_seen = hold_toggle;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99, 0) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // ------------------------------------------------------------------
   // Stimulus queue builders.
   // ------------------------------------------------------------------
   task automatic add_item(logic [PIX_W-1:0] pix, logic flush);
      stim_type s;
      s.op = OP_ITEM;
      s.pixel = pix;
      s.flush = flush;
      stim_queue.push_back(s);
   endtask

   task automatic add_csr(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      stim_type s;
      s.op = OP_CSR;
      s.csr_idx = idx;
      s.csr_data = data;
      stim_queue.push_back(s);
   endtask

   task automatic add_marker(stim_op_type op);
      stim_type s;
      s.op = op;
      stim_queue.push_back(s);
   endtask

   task automatic add_pace(int send_idle, int recv_stall);
      stim_type s;
      s.op = OP_PACE;
      s.send_idle = send_idle;
      s.recv_stall = recv_stall;
      stim_queue.push_back(s);
   endtask

   // One frame in raster order plus its tail; optionally cut short or with
   // a drain pause somewhere inside. Ignored flushes are sprinkled as noise.
   task automatic add_frame(int unsigned w, int unsigned h, bit cut, bit pause,
                            output int unsigned n);
      int unsigned total, stop_at, pause_at, style;
      logic [PIX_W-1:0] px;
      total = w * h + w + 1;
      stop_at = cut ? $urandom_range(total - 1, 1) : total;
      pause_at = pause ? $urandom_range(total - 1, 0) : total;
      style = $urandom_range(5, 0);
      n = 0;
      for (int unsigned k = 0; k < stop_at; k++) begin
         if (k == pause_at) add_marker(OP_DRAIN);
         if (k < w * h) begin
            if ($urandom_range(15, 0) == 0) add_item(PIX_W'($urandom), 1'b1);
            case (style)
               0:       px = 8'hFF;
               1:       px = $urandom_range(1, 0) ? 8'hFF : 8'h00;
               default: px = PIX_W'($urandom);
            endcase
            add_item(px, 1'b0);
         end else begin
            add_item(PIX_W'($urandom), 1'($urandom_range(1, 0)));
         end
         n++;
      end
   endtask

   // ------------------------------------------------------------------
   // Run control: build the whole stimulus, release reset, wait for the end.
   // ------------------------------------------------------------------
   initial begin
      int unsigned      n_random, frame_no, w_eff, h_eff, got, pick;
      logic [CFG_W-1:0] w_raw, h_raw;
      bit               need_cfg, hold_frame, cut, pause;

      // Directed part. Drop a write at an unmapped index: geometry stays put.
      add_pace(0, 0);
      add_csr(REG_UNMAPPED, 9'h1FF);
      // 1x1 frame: lone pixel, divisor of one
      add_csr(REG_IMAGE_WIDTH, 9'd1);
      add_csr(REG_IMAGE_HEIGHT, 9'd1);
      add_item(8'h00, 1'b1);            // flush ahead of the last pixel: no advance
      add_item(8'hFF, 1'b0);
      add_item(8'h00, 1'b1);
      add_item(8'h5A, 1'b0);            // pixel in the tail acts as a flush
      // 3x1 frame: divisors of two and three, tail fed with pixels
      add_csr(REG_IMAGE_WIDTH, 9'd3);
      for (int k = 0; k < 7; k++) add_item(8'hFF, 1'b0);
      // 3x3 checkerboard of both extremes: divisors of four, six and nine
      add_csr(REG_IMAGE_HEIGHT, 9'd3);
      for (int k = 0; k < 9; k++) add_item((k % 2) ? 8'hFF : 8'h00, 1'b0);
      for (int k = 0; k < 4; k++) add_item(8'h00, 1'b1);

      // Random part: frames of random geometry, pacing cycled per frame.
      n_random = 0;
      frame_no = 0;
      need_cfg = 1'b1;
      w_eff = 1;
      h_eff = 1;
      while (n_random < RANDOM_ITEMS) begin
         hold_frame = (frame_no == 2) || ($urandom_range(15, 0) == 0);
         if (hold_frame) begin
            // keep the sender busy while the receiver holds off
            add_pace(0, 0);
            add_marker(OP_HOLD);
         end else begin
            case (frame_no % 4)
               0: add_pace(0, 0);
               1: add_pace(78, 0);
               2: add_pace(0, 78);
               default: add_pace(25, 25);
            endcase
         end

         if (need_cfg || hold_frame || $urandom_range(4, 0) != 0) begin
            if (frame_no == 0) begin
               w_raw = 9'd256;
               h_raw = 9'd2;
            end else if (frame_no == 1) begin
               w_raw = 9'd2;
               h_raw = 9'd256;
            end else if (hold_frame) begin
               w_raw = CFG_W'($urandom_range(12, 6));
               h_raw = CFG_W'($urandom_range(8, 4));
            end else begin
               pick = $urandom_range(19, 0);
               case (pick)
                  0: begin
                     w_raw = CFG_W'($urandom_range(511, 256));   // clamps to the maximum
                     h_raw = CFG_W'($urandom_range(2, 1));
                  end
                  1: begin
                     w_raw = CFG_W'($urandom_range(2, 0));
                     h_raw = CFG_W'($urandom_range(511, 250));
                  end
                  2: begin
                     w_raw = 9'd0;                       // reads as one
                     h_raw = CFG_W'($urandom_range(6, 0));
                  end
                  default: begin
                     w_raw = CFG_W'($urandom_range(12, 1));
                     h_raw = CFG_W'($urandom_range(10, 1));
                  end
               endcase
            end
            if ($urandom_range(7, 0) == 0)
               add_csr(CSR_IDX_W'($urandom_range(15, 2)), CFG_W'($urandom));
            if ($urandom_range(1, 0)) begin
               add_csr(REG_IMAGE_WIDTH, w_raw);
               add_csr(REG_IMAGE_HEIGHT, h_raw);
            end else begin
               add_csr(REG_IMAGE_HEIGHT, h_raw);
               add_csr(REG_IMAGE_WIDTH, w_raw);
            end
            w_eff = clamp_dim(w_raw, MAX_WIDTH_DEF);
            h_eff = clamp_dim(h_raw, MAX_HEIGHT_DEF);
         end

         cut = !hold_frame && ($urandom_range(9, 0) == 0);
         pause = (frame_no == 3) || ($urandom_range(7, 0) == 0);
         add_frame(w_eff, h_eff, cut, pause, got);
         n_random += got;
         need_cfg = cut;                 // restart a broken frame by a write
         frame_no++;
      end

      repeat (RESET_LEN) @(posedge clock);
      reset <= 1'b0;

      wait (stim_done || cycle_count >= RUN_LIMIT);
      if (stim_done && mismatch_count == 0 && smoothed_expect.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ===== box_filter_3x3_edge_aware_top.f =====
+incdir+rtl
rtl/bf3_pkg.sv
rtl/bf3_line_ram.sv
rtl/bf3_ctrl.sv
rtl/bf3_window.sv
rtl/bf3_mean.sv
rtl/bf3_out_fifo.sv
rtl/box_filter_3x3_edge_aware_top.sv
tb/tb_box_filter_3x3_edge_aware_top.sv
